/* rtl/core/pbrc_pkg.sv */
// Shared types and constants of the proximity beep rate controller.
package pbrc_pkg;

    // Item kind, decided by the front part
    typedef logic [2:0] kind_t;

    localparam kind_t KIND_CHIRP = 3'd0;
    localparam kind_t KIND_OFF   = 3'd1;
    localparam kind_t KIND_ON    = 3'd2;
    localparam kind_t KIND_FAST  = 3'd3;
    localparam kind_t KIND_SLOW  = 3'd4;
    localparam kind_t KIND_RAMP  = 3'd5;

    // Band codes of the input item
    localparam logic [1:0] BAND_CLEAR   = 2'd0;
    localparam logic [1:0] BAND_FAR     = 2'd1;
    localparam logic [1:0] BAND_WARNING = 2'd2;
    localparam logic [1:0] BAND_CLOSE   = 2'd3;

    // Function codes of the input item
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_CHIRP  = 1'b1;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_WARN = 2'd0;
    localparam logic [1:0] REG_SAFE = 2'd1;
    localparam logic [1:0] REG_FAST = 2'd2;
    localparam logic [1:0] REG_SLOW = 2'd3;

    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int TIME_W   = 32;
    localparam int INTV_W   = 16;

    localparam logic [INTV_W-1:0] FAST_RESET = 16'd80;
    localparam logic [INTV_W-1:0] SLOW_RESET = 16'd600;
    localparam int WARN_RESET = 64;
    localparam int SAFE_RESET = 384;

    // Control part of one queued request
    typedef struct packed {
        kind_t kind;
        logic  neg;     // ramp descends: slow below fast
    } pbrc_ctrl_t;

endpackage

/* rtl/core/proximity_beep_rate_controller_unit.sv */
// Top level of the proximity beep rate controller: config registers, front, queue, back.
//
//   Channel   Direction  Handshake             Payload
//   -------   ---------  --------------------  ------------------------------------------
//   in        request    in_valid / in_ready   func, band, distance, ref_distance, now_ms
//   out       result     out_valid / out_ready buzzer_on, started, stopped
//   cfg       APB write  psel/penable/pwrite   paddr, pwdata (prdata on reads)
//
// Flow: the front classifies a request in the cycle it is accepted and
// drops it into a two-entry queue. The back moves chirp, off, on and
// clamped warning requests from idle to the finish state; a warning request
// on the ramp first runs the 16-step restoring divider, then the adjust state forms the interval.
// Reset: all control state clears at once; no clearing pass is needed.
// Stalls: a held result does not block the front until the queue fills.
module proximity_beep_rate_controller_unit #(
    parameter int DIST_BITS = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic [1:0]                   band,
    input  logic [DIST_BITS-1:0]         distance,
    input  logic [DIST_BITS-1:0]         ref_distance,
    input  logic [pbrc_pkg::TIME_W-1:0]  now_ms,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         buzzer_on,
    output logic                         started,
    output logic                         stopped,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbrc_pkg::ADDR_W-1:0]  paddr,
    input  logic [pbrc_pkg::DATA_W-1:0]  pwdata,
    output logic [pbrc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import pbrc_pkg::*;

    localparam int PW = DIST_BITS + INTV_W;
    localparam int CW = $bits(pbrc_ctrl_t);
    localparam int QW = CW + TIME_W + PW + DIST_BITS;

    // Configuration registers
    logic [DIST_BITS-1:0] warn_reg, warn_next;
    logic [DIST_BITS-1:0] safe_reg, safe_next;
    logic [INTV_W-1:0]    fast_reg, fast_next;
    logic [INTV_W-1:0]    slow_reg, slow_next;
    logic                 cfg_wr;
    logic [1:0]           cfg_idx;

    // Front to queue
    pbrc_ctrl_t           f_ctrl;
    logic [PW-1:0]        f_prod;
    logic [DIST_BITS-1:0] f_span;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_empty;
    logic                 q_full;
    logic [QW-1:0]        q_wdata;
    logic [QW-1:0]        q_rdata;

    // Queue to back
    pbrc_ctrl_t           b_ctrl;
    logic [TIME_W-1:0]    b_now;
    logic [PW-1:0]        b_prod;
    logic [DIST_BITS-1:0] b_span;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    // Register writes land on the access phase; unused data bits drop
    always_comb
    begin
        warn_next = warn_reg;
        safe_next = safe_reg;
        fast_next = fast_reg;
        slow_next = slow_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_WARN: warn_next = pwdata[DIST_BITS-1:0];
                REG_SAFE: safe_next = pwdata[DIST_BITS-1:0];
                REG_FAST: fast_next = pwdata[INTV_W-1:0];
                REG_SLOW: slow_next = pwdata[INTV_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_WARN: prdata = DATA_W'(warn_reg);
            REG_SAFE: prdata = DATA_W'(safe_reg);
            REG_FAST: prdata = DATA_W'(fast_reg);
            REG_SLOW: prdata = DATA_W'(slow_reg);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_reg <= DIST_BITS'(WARN_RESET);
            safe_reg <= DIST_BITS'(SAFE_RESET);
            fast_reg <= FAST_RESET;
            slow_reg <= SLOW_RESET;
        end
        else
        begin
            warn_reg <= warn_next;
            safe_reg <= safe_next;
            fast_reg <= fast_next;
            slow_reg <= slow_next;
        end
    end

    // Classify the request and form the ramp product
    pbrc_front #(
        .DIST_BITS(DIST_BITS)
    ) u_front (
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .band             (band),
        .distance         (distance),
        .ref_distance     (ref_distance),
        .ramp_start       (warn_reg),
        .ramp_end         (safe_reg),
        .fast_interval_ms (fast_reg),
        .slow_interval_ms (slow_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .ctrl             (f_ctrl),
        .prod             (f_prod),
        .span_out         (f_span)
    );

    assign q_wdata = {f_ctrl, now_ms, f_prod, f_span};

    pbrc_fifo #(
        .WIDTH(QW),
        .DEPTH(2)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    assign {b_ctrl, b_now, b_prod, b_span} = q_rdata;

    // Carry out the request and hold the result until taken
    pbrc_back #(
        .DIST_BITS(DIST_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .ctrl             (b_ctrl),
        .prod             (b_prod),
        .span             (b_span),
        .now              (b_now),
        .fast_interval_ms (fast_reg),
        .slow_interval_ms (slow_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .buzzer_on        (buzzer_on),
        .started          (started),
        .stopped          (stopped)
    );

endmodule

/* rtl/core/pbrc_front.sv */
// Front part: accept a request, classify it and form the ramp product.
module pbrc_front #(
    parameter int DIST_BITS = 13
) (
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [1:0]                     band,
    input  logic [DIST_BITS-1:0]           distance,
    input  logic [DIST_BITS-1:0]           ref_distance,
    input  logic [DIST_BITS-1:0]           ramp_start,
    input  logic [DIST_BITS-1:0]           ramp_end,
    input  logic [pbrc_pkg::INTV_W-1:0]    fast_interval_ms,
    input  logic [pbrc_pkg::INTV_W-1:0]    slow_interval_ms,
    input  logic                           q_full,
    output logic                           q_push,
    output pbrc_pkg::pbrc_ctrl_t           ctrl,
    output logic [DIST_BITS+pbrc_pkg::INTV_W-1:0] prod,
    output logic [DIST_BITS-1:0]           span_out
);
    import pbrc_pkg::*;

    localparam int NW = DIST_BITS + 2;
    localparam int PW = DIST_BITS + INTV_W;

    logic signed [NW-1:0]        num;
    logic signed [NW-1:0]        span_ext;
    logic signed [DIST_BITS:0]   span;
    logic signed [INTV_W:0]      diff;
    logic        [INTV_W:0]      ndiff;
    logic        [INTV_W-1:0]    mag;
    logic                        num_le0;
    logic                        span_le0;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        num      = $signed({2'b00, distance}) - $signed({2'b00, ref_distance})
                 - $signed({2'b00, ramp_start});
        span     = $signed({1'b0, ramp_end}) - $signed({1'b0, ramp_start});
        span_ext = $signed({span[DIST_BITS], span});
        diff     = $signed({1'b0, slow_interval_ms}) - $signed({1'b0, fast_interval_ms});
        ndiff    = -diff;
        mag      = diff[INTV_W] ? ndiff[INTV_W-1:0] : diff[INTV_W-1:0];
        num_le0  = num[NW-1] || (num == '0);
        span_le0 = span[DIST_BITS] || (span == '0);

        ctrl.neg = diff[INTV_W];
        if (func == FUNC_CHIRP)
        begin
            ctrl.kind = KIND_CHIRP;
        end
        else
        begin
            case (band)
                BAND_CLEAR, BAND_FAR: ctrl.kind = KIND_OFF;
                BAND_CLOSE:           ctrl.kind = KIND_ON;
                default:
                begin
                    if (num_le0)
                        ctrl.kind = KIND_FAST;
                    else if (span_le0 || (num >= span_ext))
                        ctrl.kind = KIND_SLOW;
                    else
                        ctrl.kind = KIND_RAMP;
                end
            endcase
        end

        // Only meaningful for a ramp request, where 0 < num < span
        prod     = PW'(num[DIST_BITS-1:0]) * PW'(mag);
        span_out = span[DIST_BITS-1:0];
    end

endmodule

/* rtl/core/pbrc_fifo.sv */
// Short request queue between the front and back parts.
module pbrc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign rdata = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        if (pop)
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wdata;
    end

endmodule

/* rtl/core/pbrc_back.sv */
// Back part: ramp divider, toggle timer, buzzer state and result register.
module pbrc_back #(
    parameter int DIST_BITS = 13
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    output logic                           q_pop,
    input  pbrc_pkg::pbrc_ctrl_t           ctrl,
    input  logic [DIST_BITS+pbrc_pkg::INTV_W-1:0] prod,
    input  logic [DIST_BITS-1:0]           span,
    input  logic [pbrc_pkg::TIME_W-1:0]    now,
    input  logic [pbrc_pkg::INTV_W-1:0]    fast_interval_ms,
    input  logic [pbrc_pkg::INTV_W-1:0]    slow_interval_ms,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           buzzer_on,
    output logic                           started,
    output logic                           stopped
);
    import pbrc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_ADJ  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam int CNT_W = $clog2(INTV_W);

    logic [1:0]           state_reg, state_next;
    logic                 tone_reg, tone_next;
    logic [TIME_W-1:0]    last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 buzzer_reg, buzzer_next;
    logic                 started_reg, started_next;
    logic                 stopped_reg, stopped_next;

    kind_t                kind_reg, kind_next;
    logic                 neg_reg, neg_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [DIST_BITS-1:0] span_reg, span_next;
    logic [DIST_BITS-1:0] rem_reg, rem_next;
    logic [INTV_W-1:0]    low_reg, low_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [INTV_W-1:0]    intv_reg, intv_next;

    logic [DIST_BITS:0]   trial;
    logic [DIST_BITS:0]   trial_sub;
    logic                 ge;
    logic [TIME_W-1:0]    delta;
    logic                 tone_new;

    assign out_valid = out_valid_reg;
    assign buzzer_on = buzzer_reg;
    assign started   = started_reg;
    assign stopped   = stopped_reg;

    always_comb
    begin
        state_next     = state_reg;
        tone_next      = tone_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        buzzer_next    = buzzer_reg;
        started_next   = started_reg;
        stopped_next   = stopped_reg;
        kind_next      = kind_reg;
        neg_next       = neg_reg;
        now_next       = now_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        cnt_next       = cnt_reg;
        intv_next      = intv_reg;
        q_pop          = 1'b0;

        // One restoring division step: remainder stays below span
        trial     = {rem_reg, low_reg[INTV_W-1]};
        trial_sub = trial - {1'b0, span_reg};
        ge        = (trial >= {1'b0, span_reg});

        delta    = now_reg - last_reg;
        tone_new = tone_reg;

        case (state_reg)
            S_IDLE:
            begin
                // Take a request only when the result slot will be free
                if (!q_empty && (!out_valid_reg || out_ready))
                begin
                    q_pop     = 1'b1;
                    kind_next = ctrl.kind;
                    neg_next  = ctrl.neg;
                    now_next  = now;
                    span_next = span;
                    rem_next  = prod[DIST_BITS+INTV_W-1:INTV_W];
                    low_next  = prod[INTV_W-1:0];
                    cnt_next  = '0;
                    intv_next = (ctrl.kind == KIND_SLOW) ? slow_interval_ms
                                                         : fast_interval_ms;
                    state_next = (ctrl.kind == KIND_RAMP) ? S_DIV : S_FIN;
                end
            end
            S_DIV:
            begin
                rem_next = ge ? trial_sub[DIST_BITS-1:0] : trial[DIST_BITS-1:0];
                low_next = {low_reg[INTV_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(INTV_W - 1))
                    state_next = S_ADJ;
            end
            S_ADJ:
            begin
                // Descending ramp rounds the magnitude up, so the sum truncates
                if (neg_reg)
                    intv_next = fast_interval_ms - low_reg - INTV_W'(|rem_reg);
                else
                    intv_next = fast_interval_ms + low_reg;
                state_next = S_FIN;
            end
            default:
            begin
                case (kind_reg)
                    KIND_CHIRP:
                    begin
                        tone_new  = 1'b0;
                        last_next = now_reg;
                    end
                    KIND_OFF: tone_new = 1'b0;
                    KIND_ON:  tone_new = 1'b1;
                    default:
                    begin
                        if (delta >= TIME_W'(intv_reg))
                        begin
                            tone_new  = !tone_reg;
                            last_next = now_reg;
                        end
                    end
                endcase
                tone_next      = tone_new;
                out_valid_next = 1'b1;
                buzzer_next    = tone_new;
                started_next   = !tone_reg && tone_new;
                stopped_next   = tone_reg && !tone_new;
                state_next     = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tone_reg      <= 1'b0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            buzzer_reg    <= 1'b0;
            started_reg   <= 1'b0;
            stopped_reg   <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tone_reg      <= tone_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            buzzer_reg    <= buzzer_next;
            started_reg   <= started_next;
            stopped_reg   <= stopped_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        neg_reg  <= neg_next;
        now_reg  <= now_next;
        span_reg <= span_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        intv_reg <= intv_next;
    end

endmodule

/* rtl/core/pbrc_checker.sv */
// Port-level checker for the proximity beep rate controller, bound to the top level.
module pbrc_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic buzzer_on,
    input logic started,
    input logic stopped
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({buzzer_on, started, stopped}))
        else $error("result changed or dropped while stalled");

    a_start_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && started |-> buzzer_on)
        else $error("start reported with buzzer off");

    a_stop_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stopped |-> !buzzer_on)
        else $error("stop reported with buzzer on");

    a_one_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(started && stopped))
        else $error("start and stop in one result");

endmodule

bind proximity_beep_rate_controller_unit pbrc_checker u_pbrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .buzzer_on (buzzer_on),
    .started   (started),
    .stopped   (stopped)
);

/* verif/tb.sv */
// Testbench for the proximity beep rate controller: directed and random requests checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbrc_pkg::*;

    localparam int DW             = 13;
    localparam int WATCHDOG_LIMIT = 2000;
    // longest request (ramp divide) plus the two-entry queue, with margin
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 240;

    // One expected result: tone state after the request and its edges
    typedef struct packed {
        logic on;
        logic start;
        logic stop;
    } buzz_t;

    logic              clk;
    logic              rst_n;

    logic              in_valid;
    logic              in_ready;
    logic              func;
    logic [1:0]        band;
    logic [DW-1:0]     distance;
    logic [DW-1:0]     ref_distance;
    logic [TIME_W-1:0] now_ms;

    logic              out_valid;
    logic              out_ready;
    logic              buzzer_on;
    logic              started;
    logic              stopped;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Predictor copy of the configuration registers
    logic [DW-1:0]     warn_q;
    logic [DW-1:0]     safe_q;
    logic [15:0]       fast_q;
    logic [15:0]       slow_q;

    // Predictor copy of the buzzer state
    logic              tone_q;
    logic [31:0]       toggle_ms;

    // Running millisecond time used to build requests
    logic [31:0]       clock_ms;

    buzz_t             pending_buzz[$];
    int                err_count;
    bit                idle_en;
    int                stall_left = 0;

    proximity_beep_rate_controller_unit #(
        .DIST_BITS(DW)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .band        (band),
        .distance    (distance),
        .ref_distance(ref_distance),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .buzzer_on   (buzzer_on),
        .started     (started),
        .stopped     (stopped),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial clk = 1'b0;

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Toggle interval of a warning request. Below the ramp take the fast
    // interval, above it (or on a collapsed ramp) the slow one; on the ramp
    // interpolate exactly and round toward minus infinity once.
    function automatic logic [31:0] toggle_interval(input logic [DW-1:0] meas,
                                                    input logic [DW-1:0] park);
        longint num;
        longint span;
        longint delta;
        longint q;
        num   = longint'(meas) - longint'(park) - longint'(warn_q);
        span  = longint'(safe_q) - longint'(warn_q);
        delta = longint'(slow_q) - longint'(fast_q);
        if (num <= 0)
            return 32'(fast_q);
        if (span <= 0 || num >= span)
            return 32'(slow_q);
        if (delta >= 0)
            q = (num * delta) / span;
        else
            q = -((num * (-delta) + span - 1) / span);
        return 32'(longint'(fast_q) + q);
    endfunction

    // Advance the buzzer state by one request and return the result it causes.
    function automatic buzz_t buzzer_step(input logic f, input logic [1:0] b,
                                          input logic [DW-1:0] meas,
                                          input logic [DW-1:0] park,
                                          input logic [31:0] t);
        logic  was_on;
        buzz_t r;
        was_on = tone_q;
        if (f == FUNC_CHIRP)
        begin
            // chirp: force off and restart the toggle timer
            tone_q    = 1'b0;
            toggle_ms = t;
        end
        else if (b == BAND_CLEAR || b == BAND_FAR)
        begin
            tone_q = 1'b0;
        end
        else if (b == BAND_CLOSE)
        begin
            tone_q = 1'b1;
        end
        else if (t - toggle_ms >= toggle_interval(meas, park))
        begin
            // elapsed time wraps modulo 2^32
            toggle_ms = t;
            tone_q    = ~tone_q;
        end
        r.on    = tone_q;
        r.start = !was_on && tone_q;
        r.stop  = was_on && !tone_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, checking, watchdog
    // ------------------------------------------------------------------

    // Stall the result channel in random bursts while idling is on.
    always @(posedge clk)
    begin
        if (!idle_en)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 12);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    function automatic void flag_mismatch(input string what, input logic exp_v,
                                          input logic act_v);
        err_count++;
        if (err_count <= 10)
            $display("mismatch on %s: expected %b, got %b at %0t", what, exp_v, act_v, $time);
    endfunction

    // Compare every accepted result with the oldest pending expectation.
    always @(posedge clk)
    begin
        buzz_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_buzz.size() == 0)
            begin
                flag_mismatch("result with no request pending", 1'bx, buzzer_on);
            end
            else
            begin
                want = pending_buzz.pop_front();
                if (buzzer_on !== want.on)
                    flag_mismatch("buzzer_on", want.on, buzzer_on);
                if (started !== want.start)
                    flag_mismatch("started", want.start, started);
                if (stopped !== want.stop)
                    flag_mismatch("stopped", want.stop, stopped);
            end
        end
    end

    // End the run if neither channel moves for too long.
    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request, hold it until accepted, then queue its result.
    // Valid is left high on acceptance until the next call or settle().
    task automatic send_request(input logic f, input logic [1:0] b,
                                input logic [DW-1:0] meas, input logic [DW-1:0] park,
                                input logic [31:0] t);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        band         <= b;
        distance     <= meas;
        ref_distance <= park;
        now_ms       <= t;
        do
            @(posedge clk);
        while (!in_ready);
        pending_buzz.push_back(buzzer_step(f, b, meas, park, t));
    endtask

    // Send a warning request timed relative to the toggle boundary:
    // slack -1 is one ms short, 0 lands exactly on it.
    task automatic send_warning(input logic [DW-1:0] meas, input logic [DW-1:0] park,
                                input int slack);
        clock_ms = toggle_ms + toggle_interval(meas, park) + 32'(slack);
        send_request(FUNC_UPDATE, BAND_WARNING, meas, park, clock_ms);
    endtask

    // Drop valid and wait until every result is back and the block is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_buzz.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One APB write: setup then access; psel stays high into the next write.
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // Write all four registers; call only while the block is idle.
    task automatic load_config(input logic [DW-1:0] w, input logic [DW-1:0] s,
                               input logic [15:0] f, input logic [15:0] sl);
        settle();
        write_reg(REG_WARN, DATA_W'(w));
        write_reg(REG_SAFE, DATA_W'(s));
        write_reg(REG_FAST, DATA_W'(f));
        write_reg(REG_SLOW, DATA_W'(sl));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        warn_q  = w;
        safe_q  = s;
        fast_q  = f;
        slow_q  = sl;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Bands that need no timing, and the chirp reset from both tone states.
    task automatic test_band_basics();
        send_request(FUNC_UPDATE, BAND_CLEAR, '0, '0, 32'd0);
        send_request(FUNC_UPDATE, BAND_CLOSE, '1, '0, 32'd5);
        send_request(FUNC_UPDATE, BAND_CLOSE, '1, '1, 32'd6);
        send_request(FUNC_UPDATE, BAND_FAR, '0, '1, 32'd7);
        send_request(FUNC_UPDATE, BAND_CLOSE, 13'd10, 13'd20, 32'd8);
        send_request(FUNC_CHIRP, BAND_CLOSE, '1, '1, 32'd100);
        send_request(FUNC_CHIRP, BAND_WARNING, '0, '0, 32'd101);
    endtask

    // Toggle boundaries at both ends and inside the default ramp, plus a
    // timer that wraps past 2^32.
    task automatic test_toggle_timing();
        send_warning('1, '0, -1);
        send_warning('1, '0, 0);
        send_warning('0, '1, -1);
        send_warning('0, '1, 0);
        send_warning(13'd324, 13'd100, 0);
        // one step below the slow end of the ramp
        send_warning(13'd483, 13'd100, -1);
        send_warning(13'd483, 13'd100, 0);
        send_request(FUNC_CHIRP, BAND_CLEAR, '0, '0, 32'hFFFF_FFF0);
        send_warning('0, '0, 0);
        send_request(FUNC_UPDATE, BAND_CLEAR, '1, '1, 32'hFFFF_FFFF);
    endtask

    // Safe offset not above warn offset: the ramp collapses to a step.
    task automatic test_collapsed_ramp();
        load_config(13'd400, 13'd200, 16'd100, 16'd900);
        send_warning(13'd1401, 13'd1000, -1);
        send_warning(13'd1401, 13'd1000, 0);
        send_warning(13'd1400, 13'd1000, 0);
    endtask

    // Slow interval below fast: the ramp descends and rounds downward.
    task automatic test_falling_ramp();
        load_config(13'd0, 13'd7, 16'd1000, 16'd200);
        send_warning(13'd503, 13'd500, -1);
        send_warning(13'd503, 13'd500, 0);
        send_warning(13'd506, 13'd500, 0);
    endtask

    // Widest ramp, zero fast interval and the largest slow interval.
    task automatic test_extreme_config();
        load_config(13'd0, 13'd8191, 16'd0, 16'hFFFF);
        send_warning('1, '0, 0);
        send_warning(13'd4096, '0, -1);
        send_warning(13'd4096, '0, 0);
        send_warning('0, '0, 0);
    endtask

    // Random traffic under the current configuration. Most requests are
    // warning-band readings, mostly around the ramp and near the toggle boundary;
    // the rest are band changes, chirps and fully random noise.
    task automatic test_random_traffic(input int n_items, input bit allow_idle);
        int            pick;
        int            reach;
        logic [DW-1:0] park;
        logic [DW-1:0] meas;
        park     = DW'($urandom);
        clock_ms = $urandom;
        for (int k = 0; k < n_items; k++)
        begin
            // alternate stretches with and without idling
            if (k % 60 == 0)
                idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                if ($urandom_range(0, 19) == 0)
                    park = DW'($urandom);
                reach = (safe_q > warn_q) ? int'(safe_q - warn_q) + 1 : 2;
                if ($urandom_range(0, 9) < 7)
                    meas = DW'(park + warn_q + $urandom_range(0, reach) - 1);
                else
                    meas = DW'($urandom);
                case ($urandom_range(0, 4))
                    0: send_warning(meas, park, -1);
                    1: send_warning(meas, park, 0);
                    2: send_warning(meas, park, $urandom_range(1, 40));
                    default:
                    begin
                        clock_ms += $urandom_range(0, 700);
                        send_request(FUNC_UPDATE, BAND_WARNING, meas, park, clock_ms);
                    end
                endcase
            end
            else if (pick < 70)
            begin
                clock_ms += $urandom_range(0, 300);
                send_request(FUNC_UPDATE, BAND_CLOSE, DW'($urandom), DW'($urandom), clock_ms);
            end
            else if (pick < 80)
            begin
                clock_ms += $urandom_range(0, 300);
                send_request(FUNC_UPDATE, pick[0] ? BAND_FAR : BAND_CLEAR,
                             DW'($urandom), park, clock_ms);
            end
            else if (pick < 88)
            begin
                clock_ms += $urandom_range(0, 300);
                send_request(FUNC_CHIRP, 2'($urandom), DW'($urandom), DW'($urandom), clock_ms);
            end
            else
            begin
                send_request(1'($urandom), 2'($urandom), DW'($urandom), DW'($urandom),
                             $urandom);
            end
        end
    endtask

    // Walk through several register settings, extremes included; the last
    // phase runs with no idling on either side.
    task automatic test_random_phases();
        load_config(DW'(WARN_RESET), DW'(SAFE_RESET), FAST_RESET, SLOW_RESET);
        test_random_traffic(PHASE_ITEMS, 1'b1);
        load_config(13'd0, 13'd8191, 16'd0, 16'hFFFF);
        test_random_traffic(PHASE_ITEMS, 1'b1);
        load_config(13'd8191, 13'd8191, 16'hFFFF, 16'hFFFF);
        test_random_traffic(PHASE_ITEMS, 1'b1);
        load_config(13'd0, 13'd0, 16'd0, 16'd0);
        test_random_traffic(PHASE_ITEMS, 1'b1);
        // descending ramp with a short span to stress rounding
        load_config(DW'($urandom_range(0, 200)), DW'($urandom_range(201, 260)),
                    16'($urandom_range(2000, 65535)), 16'($urandom_range(0, 1999)));
        test_random_traffic(PHASE_ITEMS, 1'b1);
        // safe offset below warn offset
        load_config(DW'($urandom_range(100, 8191)), DW'($urandom_range(0, 99)),
                    16'($urandom_range(0, 400)), 16'($urandom_range(0, 2000)));
        test_random_traffic(PHASE_ITEMS, 1'b1);
        load_config(DW'($urandom), DW'($urandom), 16'($urandom_range(0, 3000)),
                    16'($urandom_range(0, 3000)));
        test_random_traffic(PHASE_ITEMS, 1'b1);
        load_config(DW'($urandom_range(0, 500)), DW'($urandom_range(0, 1500)),
                    16'($urandom), 16'($urandom));
        test_random_traffic(PHASE_ITEMS, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        // drive every input to a known value before the first edge
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_UPDATE;
        band         = BAND_CLEAR;
        distance     = '0;
        ref_distance = '0;
        now_ms       = '0;
        out_ready    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;

        // predictor starts from the reset state
        warn_q       = DW'(WARN_RESET);
        safe_q       = DW'(SAFE_RESET);
        fast_q       = FAST_RESET;
        slow_q       = SLOW_RESET;
        tone_q       = 1'b0;
        toggle_ms    = '0;
        clock_ms     = '0;
        err_count    = 0;
        idle_en      = 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_band_basics();
        test_toggle_timing();
        test_collapsed_ramp();
        test_falling_ramp();
        test_extreme_config();
        test_random_phases();

        // drain the last results, then let the block go quiet
        settle();
        if (err_count == 0 && pending_buzz.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
